// ----- src/ecf_pkg.sv -----
// ----------------------------------------------------------------------------
// ecf_pkg: shared types and constants for elevation cell fusion
// Cell record, pipeline payloads, action codes and register indexes.
// ----------------------------------------------------------------------------
package ecf_pkg;

    localparam int GRID_WIDTH_DEF  = 256;
    localparam int GRID_HEIGHT_DEF = 256;
    localparam int MAX_DEPTH       = 65536;
    localparam int IDX_W           = 16;
    localparam int QUO_W           = 32;
    localparam int DEN_W           = 17;
    localparam int TRACK_STAGES    = 2 * QUO_W + 5;

    localparam logic [31:0] THRESH_RESET = 32'd10000;
    localparam logic        SWAP_RESET   = 1'b1;

    localparam int RANGE_NEAR = -4;
    localparam int RANGE_FAR  = 4;
    localparam int FLAT_JUMP  = 100;

    typedef enum logic [2:0] {
        ACT_SKIP    = 3'd0,
        ACT_INIT    = 3'd1,
        ACT_REPLACE = 3'd2,
        ACT_RESTORE = 3'd3,
        ACT_MERGE   = 3'd4
    } action_t;

    typedef enum logic {
        CFG_THRESHOLD = 1'b0,
        CFG_SWAP      = 1'b1
    } cfg_index_t;

    typedef struct packed {
        logic        [15:0] n;
        logic signed [23:0] zmax;
        logic signed [23:0] zmin;
        logic signed [23:0] zmean;
        logic        [31:0] zvar;
        logic        [31:0] stamp;
        logic        [31:0] range;
    } cell_t;

    typedef struct packed {
        logic              grid;
        logic              last;
        logic [IDX_W-1:0]  idx;
        cell_t             rec;
    } item_t;

    typedef struct packed {
        cell_t             res;
        action_t           act;
        logic [IDX_W-1:0]  idx;
        logic              last;
        logic              merged;
        logic              vsat;
    } tail_t;

endpackage

// ----- src/ecf_ram.sv -----
// ----------------------------------------------------------------------------
// ecf_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ecf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/ecf_div.sv -----
// ----------------------------------------------------------------------------
// ecf_div: pipelined restoring divider
// One quotient bit per stage; the high dividend part must be below the divisor.
// ----------------------------------------------------------------------------
module ecf_div
    import ecf_pkg::*;
#(
    parameter int QW = QUO_W,
    parameter int DW = DEN_W,
    parameter int PW = 1
)(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] in_hi,
    input  logic [QW-1:0] in_lo,
    input  logic [DW-1:0] in_den,
    input  logic [PW-1:0] in_pay,
    output logic          out_valid,
    output logic [QW-1:0] out_quo,
    output logic [DW-1:0] out_rem,
    output logic [PW-1:0] out_pay
);

    logic [QW-1:0] valid_reg;
    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] sh_reg  [QW];
    logic [DW-1:0] den_reg [QW];
    logic [PW-1:0] pay_reg [QW];

    for (genvar k = 0; k < QW; k++)
    begin : g_stage
        logic          valid_in;
        logic [DW-1:0] rem_in;
        logic [QW-1:0] sh_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;
        logic          ge;
        logic [DW-1:0] rem_next;
        logic [QW-1:0] sh_next;

        if (k == 0)
        begin : g_first
            assign valid_in = in_valid;
            assign rem_in   = in_hi;
            assign sh_in    = in_lo;
            assign den_in   = in_den;
            assign pay_in   = in_pay;
        end
        else
        begin : g_rest
            assign valid_in = valid_reg[k-1];
            assign rem_in   = rem_reg[k-1];
            assign sh_in    = sh_reg[k-1];
            assign den_in   = den_reg[k-1];
            assign pay_in   = pay_reg[k-1];
        end

        assign trial    = {rem_in, sh_in[QW-1]};
        assign diff     = trial - {1'b0, den_in};
        assign ge       = (trial >= {1'b0, den_in});
        assign rem_next = ge ? diff[DW-1:0] : trial[DW-1:0];
        assign sh_next  = {sh_in[QW-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k] <= valid_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= rem_next;
                sh_reg[k]  <= sh_next;
                den_reg[k] <= den_in;
                pay_reg[k] <= pay_in;
            end
        end
    end

    assign out_valid = valid_reg[QW-1];
    assign out_quo   = sh_reg[QW-1];
    assign out_rem   = rem_reg[QW-1];
    assign out_pay   = pay_reg[QW-1];

endmodule

// ----- src/ecf_track.sv -----
// ----------------------------------------------------------------------------
// ecf_track: in-flight cell index tracker
// Shadow of the pipeline; flags a new index that is still being updated.
// ----------------------------------------------------------------------------
module ecf_track
    import ecf_pkg::*;
#(
    parameter int STAGES = TRACK_STAGES
)(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             push,
    input  logic [IDX_W-1:0] push_idx,
    input  logic [IDX_W-1:0] probe_idx,
    output logic             hit
);

    logic [STAGES-1:0] valid_reg;
    logic [IDX_W-1:0]  idx_reg [STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[STAGES-2:0], push};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx_reg[0] <= push_idx;
            for (int k = 1; k < STAGES; k++)
            begin
                idx_reg[k] <= idx_reg[k-1];
            end
        end
    end

    always_comb
    begin
        hit = 1'b0;
        for (int k = 0; k < STAGES; k++)
        begin
            if (valid_reg[k] && (idx_reg[k] == probe_idx))
            begin
                hit = 1'b1;
            end
        end
    end

endmodule

// ----- src/elevation_cell_fusion_top.sv -----
// ----------------------------------------------------------------------------
// elevation_cell_fusion_top: fuse fresh grid cells into a stored elevation map
// Streaming mean/variance merge with flat/vertical classification and ground
// backup.
// ----------------------------------------------------------------------------
// One transfer is taken per cycle while s_tready is high; one result leaves
// per transfer, via 69 pipeline stages plus the output register. Most are two
// 32-stage divider passes in series: one forms the new cell's variance, then
// two dividers side by side form the merged mean and variance. A transfer
// whose cell_index is still in flight waits until that cell has been written
// back. After reset both stores are cleared, one cell per cycle, over all
// GRID_WIDTH*GRID_HEIGHT cells (max 65536); s_tready is low during that pass.
// ----------------------------------------------------------------------------
module elevation_cell_fusion_top
    import ecf_pkg::*;
#(
    parameter int GRID_WIDTH  = GRID_WIDTH_DEF,
    parameter int GRID_HEIGHT = GRID_HEIGHT_DEF
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_index,
    input  logic [31:0]  cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cell_index, new_count, new_zmax, new_zmin, new_zmean, new_sq_sum,
    // new_stamp, new_range_sq
    input  logic [199:0] s_tdata,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_index, fused_count, fused_zmax, fused_zmin, fused_zmean, fused_var,
    // fused_stamp, fused_range_sq
    output logic [199:0] m_tdata,
    // action
    output logic [2:0]   m_tuser,
    output logic         m_tlast
);

    localparam int CELLS     = GRID_WIDTH * GRID_HEIGHT;
    localparam int MEM_DEPTH = (CELLS < MAX_DEPTH) ? CELLS : MAX_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CELL_W    = $bits(cell_t);

    logic [31:0] thr_reg;
    logic        swap_reg;
    logic        clr_busy_reg;
    logic [AW-1:0] clr_addr_reg;

    logic  en;
    logic  hit;
    logic  push;
    item_t in_item;
    logic [DEN_W-1:0] in_den;

    logic             d1_valid;
    logic [QUO_W-1:0] d1_quo;
    item_t            d1_pay;

    logic [CELL_W-1:0] map_rdata;
    logic [CELL_W-1:0] gnd_rdata;
    logic              map_we;
    logic [AW-1:0]     map_waddr;
    logic [CELL_W-1:0] map_wdata;
    logic              gnd_we;
    logic [AW-1:0]     gnd_waddr;
    logic [CELL_W-1:0] gnd_wdata;

    logic  d_valid_reg;
    item_t d_item_reg;
    item_t d_item_next;

    cell_t   cur;
    cell_t   gnd;
    cell_t   nw;
    logic signed [32:0] dr;
    logic signed [24:0] md;
    logic    vert;
    logic    cur_vert;
    action_t d_act;
    cell_t   d_sel;
    cell_t   d_base;
    logic    d_merged;

    logic    e_valid_reg;
    action_t e_act_reg;
    logic [IDX_W-1:0] e_idx_reg;
    logic    e_last_reg;
    cell_t   e_base_reg;
    cell_t   e_d_reg;
    cell_t   e_s_reg;
    logic    e_merged_reg;

    logic [16:0] e_nsum;
    logic [15:0] e_dn1;
    logic [15:0] e_sn1;
    tail_t       f_tail_next;
    logic signed [40:0] f_pm1_next;
    logic signed [40:0] f_pm2_next;
    logic [47:0] f_pv1_next;
    logic [47:0] f_pv2_next;

    logic        f_valid_reg;
    tail_t       f_tail_reg;
    logic signed [40:0] f_pm1_reg;
    logic signed [40:0] f_pm2_reg;
    logic [47:0] f_pv1_reg;
    logic [47:0] f_pv2_reg;
    logic [16:0] f_nsum_reg;

    logic        g_valid_reg;
    tail_t       g_tail_reg;
    logic signed [41:0] g_mnum_reg;
    logic [48:0] g_vnum_reg;
    logic [16:0] g_nsum_reg;

    logic        h_valid_reg;
    tail_t       h_tail_reg;
    logic        h_mneg_reg;
    logic [40:0] h_mabs_reg;
    logic [48:0] h_vnum_reg;
    logic [16:0] h_mden_reg;
    logic [16:0] h_vden_reg;
    tail_t       h_tail_next;

    logic             dv_valid;
    logic [QUO_W-1:0] dv_quo;
    tail_t            dv_pay;
    logic             dm_valid;
    logic [QUO_W-1:0] dm_quo;
    logic [DEN_W-1:0] dm_rem;
    logic             dm_neg;
    logic             d2_valid;
    logic [23:0]      mq;
    logic [23:0]      mean;
    cell_t            fin;

    logic         m_valid_reg;
    logic [199:0] m_data_reg;
    action_t      m_act_reg;
    logic         m_last_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THRESH_RESET;
            swap_reg <= SWAP_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_THRESHOLD: thr_reg  <= cfg_wdata;
                CFG_SWAP:      swap_reg <= cfg_wdata[0];
            endcase
        end
    end

    // clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clr_busy_reg)
        begin
            if (clr_addr_reg == AW'(MEM_DEPTH - 1))
            begin
                clr_busy_reg <= 1'b0;
            end
            else
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
        end
    end

    // input side
    always_comb
    begin
        in_item.idx       = s_tdata[15:0];
        in_item.rec.n     = s_tdata[31:16];
        in_item.rec.zmax  = s_tdata[55:32];
        in_item.rec.zmin  = s_tdata[79:56];
        in_item.rec.zmean = s_tdata[103:80];
        in_item.rec.zvar  = s_tdata[135:104];
        in_item.rec.stamp = s_tdata[167:136];
        in_item.rec.range = s_tdata[199:168];
        in_item.last      = s_tlast;
        in_item.grid      = ({16'd0, s_tdata[15:0]} < 32'(CELLS));
        in_den = (s_tdata[31:16] > 16'd2) ? {1'b0, s_tdata[31:16] - 16'd1} : 17'd1;
    end

    assign en       = !d2_valid || !m_valid_reg || m_tready;
    assign s_tready = en && !hit && !clr_busy_reg;
    assign push     = s_tvalid && s_tready;

    ecf_track #(
        .STAGES (TRACK_STAGES)
    ) u_track (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .push      (push),
        .push_idx  (s_tdata[15:0]),
        .probe_idx (s_tdata[15:0]),
        .hit       (hit)
    );

    ecf_div #(
        .QW (QUO_W),
        .DW (DEN_W),
        .PW ($bits(item_t))
    ) u_div_new (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (push),
        .in_hi     ('0),
        .in_lo     (s_tdata[135:104]),
        .in_den    (in_den),
        .in_pay    (in_item),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_rem   (),
        .out_pay   (d1_pay)
    );

    // stores
    assign map_we    = clr_busy_reg || (en && d2_valid && (dv_pay.act != ACT_SKIP));
    assign map_waddr = clr_busy_reg ? clr_addr_reg : AW'(dv_pay.idx);
    assign map_wdata = clr_busy_reg ? '0 : fin;
    assign gnd_we    = clr_busy_reg || (en && d_valid_reg && (d_act == ACT_REPLACE));
    assign gnd_waddr = clr_busy_reg ? clr_addr_reg : AW'(d_item_reg.idx);
    assign gnd_wdata = clr_busy_reg ? '0 : cur;

    ecf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MEM_DEPTH)
    ) u_map_ram (
        .clk   (clk),
        .we    (map_we),
        .waddr (map_waddr),
        .wdata (map_wdata),
        .re    (en),
        .raddr (AW'(d1_pay.idx)),
        .rdata (map_rdata)
    );

    ecf_ram #(
        .WIDTH (CELL_W),
        .DEPTH (MEM_DEPTH)
    ) u_gnd_ram (
        .clk   (clk),
        .we    (gnd_we),
        .waddr (gnd_waddr),
        .wdata (gnd_wdata),
        .re    (en),
        .raddr (AW'(d1_pay.idx)),
        .rdata (gnd_rdata)
    );

    // read stage
    always_comb
    begin
        d_item_next          = d1_pay;
        d_item_next.rec.zvar = d1_quo;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= d1_valid;
            e_valid_reg <= d_valid_reg;
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
        end
    end

    // classify and choose the action
    always_comb
    begin
        cur      = cell_t'(map_rdata);
        gnd      = cell_t'(gnd_rdata);
        nw       = d_item_reg.rec;
        dr       = $signed({1'b0, cur.range}) - $signed({1'b0, nw.range});
        md       = $signed({cur.zmean[23], cur.zmean}) - $signed({nw.zmean[23], nw.zmean});
        vert     = (nw.zvar > thr_reg);
        cur_vert = (cur.zvar > thr_reg);
        d_act    = ACT_SKIP;
        if (d_item_reg.grid && (nw.n != 16'd0) && ((cur.n == 16'd0) || (dr > 33'(RANGE_NEAR))))
        begin
            priority if ((cur.n == 16'd0) || ((nw.n > 16'd2) && (dr > 33'(RANGE_FAR))))
            begin
                d_act = ACT_INIT;
            end
            else if (!swap_reg)
            begin
                d_act = ACT_MERGE;
            end
            else if (vert == cur_vert)
            begin
                d_act = (!vert && (md > 25'(FLAT_JUMP))) ? ACT_REPLACE : ACT_MERGE;
            end
            else if (vert)
            begin
                d_act = ACT_REPLACE;
            end
            else
            begin
                d_act = ACT_RESTORE;
            end
        end
        d_sel    = (d_act == ACT_RESTORE) ? gnd : cur;
        d_merged = ((d_act == ACT_RESTORE) || (d_act == ACT_MERGE)) && (d_sel.n != 16'd0);
        d_base   = d_item_reg.grid ? cur : '0;
        if ((d_act == ACT_INIT) || (d_act == ACT_REPLACE) ||
            (((d_act == ACT_RESTORE) || (d_act == ACT_MERGE)) && !d_merged))
        begin
            d_base = nw;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_item_reg   <= d_item_next;
            e_act_reg    <= d_act;
            e_idx_reg    <= d_item_reg.idx;
            e_last_reg   <= d_item_reg.last;
            e_base_reg   <= d_base;
            e_d_reg      <= d_sel;
            e_s_reg      <= nw;
            e_merged_reg <= d_merged;
        end
    end

    // merge bounds and products
    always_comb
    begin
        e_nsum = {1'b0, e_d_reg.n} + {1'b0, e_s_reg.n};
        e_dn1  = e_d_reg.n - 16'd1;
        e_sn1  = e_s_reg.n - 16'd1;
        f_tail_next.res    = e_base_reg;
        f_tail_next.act    = e_act_reg;
        f_tail_next.idx    = e_idx_reg;
        f_tail_next.last   = e_last_reg;
        f_tail_next.merged = e_merged_reg;
        f_tail_next.vsat   = 1'b0;
        if (e_merged_reg)
        begin
            f_tail_next.res       = e_d_reg;
            f_tail_next.res.n     = e_nsum[16] ? 16'hFFFF : e_nsum[15:0];
            f_tail_next.res.zmax  = (e_s_reg.zmax > e_d_reg.zmax) ? e_s_reg.zmax : e_d_reg.zmax;
            f_tail_next.res.zmin  = (e_s_reg.zmin < e_d_reg.zmin) ? e_s_reg.zmin : e_d_reg.zmin;
        end
        f_pm1_next = $signed(e_d_reg.zmean) * $signed({1'b0, e_d_reg.n});
        f_pm2_next = $signed(e_s_reg.zmean) * $signed({1'b0, e_s_reg.n});
        f_pv1_next = e_d_reg.zvar * e_dn1;
        f_pv2_next = e_s_reg.zvar * e_sn1;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_tail_reg <= f_tail_next;
            f_pm1_reg  <= f_pm1_next;
            f_pm2_reg  <= f_pm2_next;
            f_pv1_reg  <= f_pv1_next;
            f_pv2_reg  <= f_pv2_next;
            f_nsum_reg <= e_nsum;
        end
    end

    // sums
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_tail_reg <= f_tail_reg;
            g_mnum_reg <= $signed({f_pm1_reg[40], f_pm1_reg}) + $signed({f_pm2_reg[40], f_pm2_reg});
            g_vnum_reg <= {1'b0, f_pv1_reg} + {1'b0, f_pv2_reg};
            g_nsum_reg <= f_nsum_reg;
        end
    end

    // magnitude, saturation check and divisors
    always_comb
    begin
        h_tail_next      = g_tail_reg;
        h_tail_next.vsat = (g_vnum_reg[48:32] >= (g_nsum_reg - 17'd1));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_tail_reg <= h_tail_next;
            h_mneg_reg <= g_mnum_reg[41];
            h_mabs_reg <= g_mnum_reg[41] ? 41'(-g_mnum_reg) : g_mnum_reg[40:0];
            h_vnum_reg <= g_vnum_reg;
            h_mden_reg <= g_nsum_reg;
            h_vden_reg <= g_nsum_reg - 17'd1;
        end
    end

    ecf_div #(
        .QW (QUO_W),
        .DW (DEN_W),
        .PW ($bits(tail_t))
    ) u_div_var (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid_reg),
        .in_hi     (h_vnum_reg[48:32]),
        .in_lo     (h_vnum_reg[31:0]),
        .in_den    (h_vden_reg),
        .in_pay    (h_tail_reg),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_rem   (),
        .out_pay   (dv_pay)
    );

    ecf_div #(
        .QW (QUO_W),
        .DW (DEN_W),
        .PW (1)
    ) u_div_mean (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (h_valid_reg),
        .in_hi     ({8'd0, h_mabs_reg[40:32]}),
        .in_lo     (h_mabs_reg[31:0]),
        .in_den    (h_mden_reg),
        .in_pay    (h_mneg_reg),
        .out_valid (dm_valid),
        .out_quo   (dm_quo),
        .out_rem   (dm_rem),
        .out_pay   (dm_neg)
    );

    // floor the mean, saturate the variance
    always_comb
    begin
        d2_valid = dv_valid && dm_valid;
        mq       = dm_quo[23:0];
        if (!dm_neg)
        begin
            mean = mq;
        end
        else if (dm_rem != '0)
        begin
            mean = ~mq;
        end
        else
        begin
            mean = -mq;
        end
        fin = dv_pay.res;
        if (dv_pay.merged)
        begin
            fin.zmean = mean;
            fin.zvar  = dv_pay.vsat ? 32'hFFFF_FFFF : dv_quo;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en && d2_valid)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && d2_valid)
        begin
            m_data_reg <= {fin.range, fin.stamp, fin.zvar, fin.zmean, fin.zmin, fin.zmax,
                           fin.n, dv_pay.idx};
            m_act_reg  <= dv_pay.act;
            m_last_reg <= dv_pay.last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_act_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- tb/elevation_cell_fusion_top_tb.sv -----
// ----------------------------------------------------------------------------
// elevation_cell_fusion_top_tb: self-checking bench for elevation cell fusion
// A table of directed cells, then random cell streams over four register
// settings, is driven into the block. Every transfer is fused into a local
// copy of the map and ground stores, and each result is compared field by
// field against the oldest predicted cell, under random idling on both sides
// and one long receiver hold-off.
// ----------------------------------------------------------------------------
module elevation_cell_fusion_top_tb;
    import ecf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] idx;
        cell_t       rec;
        logic        last;
        bit          typed;
        action_t     typed_act;
    } stim_row_t;

    typedef struct {
        logic [15:0] idx;
        cell_t       rec;
        action_t     act;
        logic        last;
    } fused_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_wr_en = 1'b0;
    logic         cfg_index = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [199:0] s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [199:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         m_tlast;

    cell_t       map_cells [0:MAX_DEPTH-1];
    cell_t       ground_cells [0:MAX_DEPTH-1];
    logic [31:0] vert_thresh;
    logic        swap_on;
    fused_t      pending_cells[$];
    stim_row_t   dir_rows[$];
    int          errors = 0;
    int          cycle = 0;
    int          results_seen = 0;
    int          holdoff = 0;
    bit          holdoff_done = 0;

    elevation_cell_fusion_top dut (.*);

    always #1 clk = ~clk;

    always @(posedge clk) cycle <= cycle + 1;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
        $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want, results_seen);
        errors++;
    endtask

    function automatic cell_t merge_cells(input cell_t d, input cell_t s);
        int unsigned       n;
        longint            mnum;
        longint            q;
        longint unsigned   vnum;
        longint unsigned   vq;
        if (d.n == 0)
        begin
            return s;
        end
        n = int'(d.n) + int'(s.n);
        if ($signed(s.zmax) > $signed(d.zmax)) d.zmax = s.zmax;
        if ($signed(s.zmin) < $signed(d.zmin)) d.zmin = s.zmin;
        mnum = longint'($signed(d.zmean)) * longint'(d.n)
             + longint'($signed(s.zmean)) * longint'(s.n);
        q = mnum / longint'(n);
        if ((mnum % longint'(n)) != 0 && mnum < 0) q--;
        d.zmean = q[23:0];
        vnum = longint'(s.zvar) * longint'(s.n - 16'd1)
             + longint'(d.zvar) * longint'(d.n - 16'd1);
        vq = vnum / longint'(n - 1);
        d.zvar = (vq > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vq[31:0];
        d.n = (n > 65535) ? 16'hFFFF : n[15:0];
        return d;
    endfunction

    function automatic fused_t fuse_cell(input logic [15:0] idx, input cell_t nw,
                                         input logic last);
        fused_t   r;
        cell_t    cur;
        longint   dr;
        bit       vert;
        bit       cur_vert;
        cur = map_cells[idx];
        r.idx = idx;
        r.last = last;
        r.rec = cur;
        r.act = ACT_SKIP;
        dr = longint'(cur.range) - longint'(nw.range);
        if (nw.n > 0 && (cur.n == 0 || dr > RANGE_NEAR))
        begin
            if (nw.n > 2) nw.zvar = nw.zvar / (nw.n - 16'd1);
            vert = nw.zvar > vert_thresh;
            cur_vert = cur.zvar > vert_thresh;
            if (cur.n == 0 || (nw.n > 2 && dr > RANGE_FAR))
            begin
                r.rec = nw;
                r.act = ACT_INIT;
            end
            else if (swap_on)
            begin
                if (vert == cur_vert)
                begin
                    if (!vert && longint'($signed(cur.zmean)) - longint'($signed(nw.zmean))
                        > FLAT_JUMP)
                    begin
                        ground_cells[idx] = cur;
                        r.rec = nw;
                        r.act = ACT_REPLACE;
                    end
                    else
                    begin
                        r.rec = merge_cells(cur, nw);
                        r.act = ACT_MERGE;
                    end
                end
                else if (vert)
                begin
                    ground_cells[idx] = cur;
                    r.rec = nw;
                    r.act = ACT_REPLACE;
                end
                else
                begin
                    r.rec = merge_cells(ground_cells[idx], nw);
                    r.act = ACT_RESTORE;
                end
            end
            else
            begin
                r.rec = merge_cells(cur, nw);
                r.act = ACT_MERGE;
            end
            map_cells[idx] = r.rec;
        end
        return r;
    endfunction

    task automatic write_reg(input cfg_index_t which, input logic [31:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= which;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        if (which == CFG_THRESHOLD) vert_thresh = value;
        else swap_on = value[0];
    endtask

    task automatic drain();
        while (pending_cells.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic send_cell(input logic [15:0] idx, input cell_t c, input logic last,
                             input bit typed, input action_t typed_act, input bit calm);
        fused_t f;
        if (!calm)
        begin
            while ($urandom_range(0, 99) < 18)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata <= {c.range, c.stamp, c.zvar, c.zmean, c.zmin, c.zmax, c.n, idx};
        s_tlast <= last;
        do @(posedge clk); while (!s_tready);
        f = fuse_cell(idx, c, last);
        if (typed) f.act = typed_act;
        pending_cells.push_back(f);
    endtask

    task automatic add_row(input logic [15:0] idx, input logic [15:0] n,
                           input int zmax, input int zmin, input int zmean,
                           input logic [31:0] sq, input logic [31:0] stamp,
                           input logic [31:0] range, input logic last,
                           input bit typed, input action_t act);
        stim_row_t r;
        r.idx = idx;
        r.rec.n = n;
        r.rec.zmax = zmax[23:0];
        r.rec.zmin = zmin[23:0];
        r.rec.zmean = zmean[23:0];
        r.rec.zvar = sq;
        r.rec.stamp = stamp;
        r.rec.range = range;
        r.last = last;
        r.typed = typed;
        r.typed_act = act;
        dir_rows.push_back(r);
    endtask

    function automatic cell_t random_cell();
        cell_t c;
        int    m;
        int    k;
        k = $urandom_range(0, 9);
        case (k)
            0: c.n = 16'd0;
            1: c.n = 16'd1;
            2: c.n = 16'd2;
            3: c.n = 16'hFFFF;
            4: c.n = 16'($urandom());
            default: c.n = 16'($urandom_range(3, 40));
        endcase
        if ($urandom_range(0, 9) == 0)
        begin
            c.zmax = 24'($urandom());
            c.zmin = 24'($urandom());
            c.zmean = 24'($urandom());
            c.zvar = $urandom();
            c.range = $urandom();
        end
        else
        begin
            m = $urandom_range(0, 600) - 300;
            c.zmean = m[23:0];
            m = m + $urandom_range(0, 200);
            c.zmax = m[23:0];
            m = m - $urandom_range(200, 400);
            c.zmin = m[23:0];
            c.zvar = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 60000) * 40
                                                 : $urandom_range(0, 8000) * c.n;
            c.range = 32'd1000 + $urandom_range(0, 14);
        end
        c.stamp = $urandom();
        return c;
    endfunction

    task automatic random_phase(input int count);
        logic [15:0] idx;
        for (int i = 0; i < count; i++)
        begin
            idx = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 15));
            send_cell(idx, random_cell(), 1'($urandom_range(0, 1)), 0, ACT_SKIP,
                      (i >= 60 && i < 120));
        end
        s_tvalid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (holdoff > 0)
        begin
            holdoff <= holdoff - 1;
            m_tready <= 1'b0;
        end
        else if (!holdoff_done && results_seen >= 200)
        begin
            holdoff <= 400;
            holdoff_done <= 1;
            m_tready <= 1'b0;
        end
        else if (cycle % 3000 < 500)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= ($urandom_range(0, 99) >= 18);
        end
    end

    always @(posedge clk)
    begin
        fused_t want;
        cell_t  got;
        if (m_tvalid && m_tready)
        begin
            results_seen <= results_seen + 1;
            if (pending_cells.size() == 0)
            begin
                report("unexpected result", m_tdata[15:0], 0);
            end
            else
            begin
                want = pending_cells.pop_front();
                {got.range, got.stamp, got.zvar, got.zmean, got.zmin, got.zmax, got.n}
                    = m_tdata[199:16];
                if (m_tdata[15:0] != want.idx) report("out_index", m_tdata[15:0], want.idx);
                if (got.n != want.rec.n) report("fused_count", got.n, want.rec.n);
                if (got.zmax != want.rec.zmax) report("fused_zmax", got.zmax, want.rec.zmax);
                if (got.zmin != want.rec.zmin) report("fused_zmin", got.zmin, want.rec.zmin);
                if (got.zmean != want.rec.zmean)
                    report("fused_zmean", got.zmean, want.rec.zmean);
                if (got.zvar != want.rec.zvar) report("fused_var", got.zvar, want.rec.zvar);
                if (got.stamp != want.rec.stamp)
                    report("fused_stamp", got.stamp, want.rec.stamp);
                if (got.range != want.rec.range)
                    report("fused_range_sq", got.range, want.rec.range);
                if (m_tuser != want.act) report("action", m_tuser, want.act);
                if (m_tlast != want.last) report("out_last", m_tlast, want.last);
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        for (int i = 0; i < MAX_DEPTH; i++)
        begin
            map_cells[i] = '0;
            ground_cells[i] = '0;
        end
        vert_thresh = THRESH_RESET;
        swap_on = SWAP_RESET;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        write_reg(CFG_THRESHOLD, 32'd10000);
        write_reg(CFG_SWAP, 32'd1);

        add_row(5, 10, 50, -50, 0, 900, 1, 1000, 0, 1, ACT_INIT);
        add_row(5, 0, 9, 9, 9, 5, 2, 1000, 1, 1, ACT_SKIP);
        add_row(5, 4, 10, -10, 0, 30, 3, 2000, 0, 1, ACT_SKIP);
        add_row(5, 6, 40, 0, 20, 500, 4, 1000, 1, 1, ACT_MERGE);
        add_row(5, 3, -250, -350, -300, 200, 5, 1001, 0, 1, ACT_REPLACE);
        add_row(5, 8, 900, -900, -280, 8*7*50000, 6, 1000, 0, 1, ACT_REPLACE);
        add_row(5, 5, -260, -320, -290, 400, 7, 1000, 1, 1, ACT_RESTORE);
        add_row(5, 3, 5, -5, 0, 20, 8, 990, 0, 1, ACT_INIT);
        add_row(6, 1, 8388607, -8388608, -8388608, 32'hFFFFFFFF, 32'hFFFFFFFF,
                32'hFFFFFFFF, 1, 1, ACT_INIT);
        add_row(6, 2, 8388607, -8388608, 8388607, 0, 0, 32'hFFFFFFFF, 0, 1, ACT_RESTORE);
        add_row(7, 16'hFFFF, 8388607, 8388607, 8388607, 0, 9, 0, 0, 1, ACT_INIT);
        add_row(7, 16'hFFFF, 8388607, 8388600, 8388607, 0, 10, 0, 1, 1, ACT_MERGE);
        add_row(7, 2, 8388607, -8388608, 8388607, 32'hFFFFFFFF, 11, 3, 0, 0, ACT_SKIP);
        add_row(16'hFFFF, 3, -1, -8388608, -4000, 32'h8000_0000, 12, 32'h7FFF_FFFF, 1, 1,
                ACT_INIT);
        add_row(16'hFFFF, 20, 0, -8388608, -5000, 32'hFFFF_FFFF, 13, 32'h7FFF_FFFC, 0, 0,
                ACT_SKIP);
        add_row(0, 1, 0, 0, 0, 0, 0, 0, 1, 1, ACT_INIT);
        add_row(0, 40, 100, -100, -1, 40*39*3, 14, 2, 0, 0, ACT_SKIP);
        foreach (dir_rows[i])
            send_cell(dir_rows[i].idx, dir_rows[i].rec, dir_rows[i].last,
                      dir_rows[i].typed, dir_rows[i].typed_act, 0);
        s_tvalid <= 1'b0;
        random_phase(230);
        drain();

        write_reg(CFG_THRESHOLD, 32'd0);
        random_phase(230);
        drain();

        write_reg(CFG_THRESHOLD, 32'hFFFF_FFFF);
        write_reg(CFG_SWAP, 32'd0);
        random_phase(230);
        drain();

        write_reg(CFG_THRESHOLD, 32'd5000);
        write_reg(CFG_SWAP, 32'd1);
        random_phase(230);
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- sim.f -----
src/ecf_pkg.sv
src/ecf_ram.sv
src/ecf_div.sv
src/ecf_track.sv
src/elevation_cell_fusion_top.sv
tb/elevation_cell_fusion_top_tb.sv
